// ===== rtl/sha256_message_digest_unit_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-256 digest unit assertion macros
// Shared property wrappers for the concurrent checks of the digest unit.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sha256 digest unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sha256 digest unit: next-cycle check failed");

`endif

// ===== rtl/sha256md_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest unit package
// Round constants, initial hash value and the SHA-256 sigma functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256md_pkg;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_BITS  = 512;
    localparam int unsigned LEN_START   = 56;

    typedef logic [31:0] t_word;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90beffea, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message digest unit
// Hashes a byte stream and returns the 256-bit digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// The input channel takes one word per handshake: an optional message byte
// and a flag that closes the message. The output channel returns eight
// digest words, most significant first, with the last one flagged.
// A byte that does not complete a block is shifted into it. The 64th byte
// of a block starts a compression: 64 rounds on the single round unit, one
// round a cycle, then a fold into the chaining value; the input is not
// ready during the rounds and the fold.
// On the end flag the padding bytes are shifted in one a cycle, and the
// digest follows after the padding and one or two compressions. The eight
// words are then offered one a cycle; while the receiver stalls, the
// current word is held and no input is taken.
// After the last word is taken, the unit returns to the initial hash value.
// Reset clears the byte count and fill, loads the initial hash value and
// leaves the unit ready for a new message.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_message_digest_unit_macros.svh"

module sha256_message_digest_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_message_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_number,
    output logic             o_last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int unsigned BB = sha256md_pkg::BLOCK_BITS;

    logic [2:0]                r_state, n_state;
    logic [2:0]                r_after, n_after;
    logic [BB-1:0]             r_blk, n_blk;
    logic [5:0]                r_fill, n_fill;
    logic [60:0]               r_count, n_count;
    logic [5:0]                r_rnd, n_rnd;
    logic [2:0]                r_idx, n_idx;
    logic                      r_mark, n_mark;
    logic                      r_lenblk, n_lenblk;
    sha256md_pkg::t_word       r_chain [8];
    sha256md_pkg::t_word       n_chain [8];
    sha256md_pkg::t_word       r_wv [8];
    sha256md_pkg::t_word       n_wv [8];

    sha256md_pkg::t_word       w0, w1, w9, w14, w_exp, w_cur, t1, t2;
    logic [63:0]               bit_len, len_shift;
    logic [7:0]                pad_byte;
    logic                      in_acc, out_acc;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign o_digest_word = r_chain[r_idx];
    assign o_word_number = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    assign w0  = r_blk[BB-1 -: 32];
    assign w1  = r_blk[BB-33 -: 32];
    assign w9  = r_blk[BB-289 -: 32];
    assign w14 = r_blk[BB-449 -: 32];

    assign w_exp = sha256md_pkg::small_sigma1(w14) + w9 + sha256md_pkg::small_sigma0(w1) + w0;
    assign w_cur = (r_rnd < 6'd16) ? w0 : w_exp;

    assign t1 = r_wv[7] + sha256md_pkg::big_sigma1(r_wv[4])
              + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
              + sha256md_pkg::ROUND_K[r_rnd] + w_cur;
    assign t2 = sha256md_pkg::big_sigma0(r_wv[0])
              + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));

    assign bit_len   = {r_count, 3'b000};
    assign len_shift = bit_len >> {~r_fill[2:0], 3'b000};

    always_comb begin
        if (!r_mark) begin
            pad_byte = sha256md_pkg::PAD_MARK;
        end else if (r_lenblk && (r_fill >= 6'(sha256md_pkg::LEN_START))) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_blk    = r_blk;
        n_fill   = r_fill;
        n_count  = r_count;
        n_rnd    = r_rnd;
        n_idx    = r_idx;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        n_chain  = r_chain;
        n_wv     = r_wv;
        case (r_state)
            S_IDLE: begin
                n_mark   = 1'b0;
                n_lenblk = 1'b0;
                if (in_acc) begin
                    if (i_byte_present) begin
                        n_blk   = {r_blk[BB-9:0], i_message_byte};
                        n_fill  = r_fill + 6'd1;
                        n_count = r_count + 61'd1;
                        if (r_fill == 6'd63) begin
                            n_state = S_ROUND;
                            n_rnd   = 6'd0;
                            n_wv    = r_chain;
                            n_after = i_message_end ? S_PAD : S_IDLE;
                        end else if (i_message_end) begin
                            n_state = S_PAD;
                        end
                    end else if (i_message_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_blk  = {r_blk[BB-9:0], pad_byte};
                n_fill = r_fill + 6'd1;
                n_mark = 1'b1;
                if (!r_mark && (r_fill < 6'(sha256md_pkg::LEN_START))) begin
                    n_lenblk = 1'b1;
                end
                if (r_fill == 6'd63) begin
                    n_state = S_ROUND;
                    n_rnd   = 6'd0;
                    n_wv    = r_chain;
                    if (r_mark && r_lenblk) begin
                        n_after = S_OUT;
                    end else begin
                        n_after  = S_PAD;
                        n_lenblk = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                n_blk   = {r_blk[BB-33:0], w_cur};
                n_wv[7] = r_wv[6];
                n_wv[6] = r_wv[5];
                n_wv[5] = r_wv[4];
                n_wv[4] = r_wv[3] + t1;
                n_wv[3] = r_wv[2];
                n_wv[2] = r_wv[1];
                n_wv[1] = r_wv[0];
                n_wv[0] = t1 + t2;
                n_rnd   = r_rnd + 6'd1;
                if (r_rnd == 6'(sha256md_pkg::ROUNDS - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_wv[i];
                end
                n_state = r_after;
                n_idx   = 3'd0;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                        n_count = '0;
                        n_chain = sha256md_pkg::INIT_HASH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_fill   <= '0;
            r_count  <= '0;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_chain  <= sha256md_pkg::INIT_HASH;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_rnd    <= n_rnd;
            r_idx    <= n_idx;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
            r_chain  <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_wv  <= n_wv;
    end

    `SMD_ASSERT_NOW(a_one_side_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `SMD_ASSERT_NOW(a_digest_on_block_edge, i_clk, i_rst_n, o_valid, r_fill == 6'd0)
    `SMD_ASSERT_NEXT(a_rounds_then_fold, i_clk, i_rst_n,
        (r_state == S_ROUND) && (r_rnd == 6'd63), r_state == S_FOLD)
    `SMD_ASSERT_NEXT(a_last_word_frees_input, i_clk, i_rst_n,
        out_acc && o_last_word, o_ready && !o_valid && (r_count == 61'd0))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest unit testbench
// Streams byte messages into the unit and checks every digest word it returns.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own SHA-256 state, hashes each accepted input
// word as it is taken and queues the eight digest words that a closing word
// calls for. Each returned word is compared with the oldest one queued.
// A directed opening covers the empty message, zero bytes, a closing word with
// and without a byte, and ignored words. Random messages of short and
// block-boundary lengths follow, sent in bursts against a stalling receiver.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 260;

    // Round constants of the compression, first round in the top bits.
    localparam bit [2047:0] ROUND_CONSTANTS = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90beffea, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [255:0] START_CHAIN = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  number;
        logic        last;
    } t_digest_entry;

    class digest_scoreboard;
        bit [31:0]     chain [8];
        bit [7:0]      block [64];
        bit [5:0]      fill;
        bit [60:0]     byte_count;
        t_digest_entry pending_words [$];
        int            mismatches;
        int            words_checked;
        int            messages_closed;

        function new();
            restart();
            foreach (block[i]) block[i] = 8'h00;
            mismatches      = 0;
            words_checked   = 0;
            messages_closed = 0;
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = START_CHAIN[255 - 32 * i -: 32];
            fill       = '0;
            byte_count = '0;
        endfunction

        function bit [31:0] ror(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] sched [16];
            bit [31:0] v [8];
            bit [31:0] wr, s0, s1, t1, t2, e, a;
            for (int i = 0; i < 16; i++) begin
                sched[i] = {block[4 * i], block[4 * i + 1], block[4 * i + 2], block[4 * i + 3]};
            end
            v = chain;
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    wr = sched[r];
                end else begin
                    s1 = ror(sched[(r - 2) % 16], 17) ^ ror(sched[(r - 2) % 16], 19)
                       ^ (sched[(r - 2) % 16] >> 10);
                    s0 = ror(sched[(r - 15) % 16], 7) ^ ror(sched[(r - 15) % 16], 18)
                       ^ (sched[(r - 15) % 16] >> 3);
                    wr = s1 + sched[(r - 7) % 16] + s0 + sched[r % 16];
                    sched[r % 16] = wr;
                end
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                   + ((e & v[5]) ^ (~e & v[6]))
                   + ROUND_CONSTANTS[2047 - 32 * r -: 32] + wr;
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                   + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = e;
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = a;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void absorb(logic [7:0] data, logic present, logic closing);
            bit [63:0]     bit_len;
            t_digest_entry entry;
            if (present) begin
                block[fill] = data;
                fill        = fill + 1'b1;
                byte_count  = byte_count + 1'b1;
                if (fill == 0) compress();
            end
            if (!closing) return;
            bit_len     = {byte_count, 3'b000};
            block[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++) block[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                foreach (block[i]) block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) block[63 - i] = bit_len[8 * i +: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                entry.word   = chain[i];
                entry.number = i[2:0];
                entry.last   = (i == 7);
                pending_words.push_back(entry);
            end
            messages_closed++;
            restart();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_word(logic [31:0] word, logic [2:0] number, logic last);
            t_digest_entry entry;
            words_checked++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("digest word %08h with none pending", word));
                return;
            end
            entry = pending_words.pop_front();
            if (word !== entry.word)
                report_mismatch($sformatf("word %0d is %08h, predicted %08h",
                                          entry.number, word, entry.word));
            if (number !== entry.number)
                report_mismatch($sformatf("word number is %0d, predicted %0d",
                                          number, entry.number));
            if (last !== entry.last)
                report_mismatch($sformatf("last flag on word %0d is %b, predicted %b",
                                          entry.number, last, entry.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_message_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_message_end  = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_last_word;

    digest_scoreboard sb = new();

    int        cycle_count   = 0;
    int        words_sent    = 0;
    int        burst_left    = 1;
    int        longest_msg   = 0;
    bit [15:0] stall_pattern = 16'hffff;
    bit [3:0]  stall_slot    = '0;

    sha256_message_digest_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_message_byte (i_message_byte),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_number  (o_word_number),
        .o_last_word    (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d digest words outstanding.",
                     sb.pending_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.absorb(i_message_byte, i_byte_present, i_message_end);
            if (o_valid && i_ready) sb.check_word(o_digest_word, o_word_number, o_last_word);
        end
    end

    always @(posedge i_clk) begin
        i_ready    <= stall_pattern[stall_slot];
        stall_slot <= stall_slot + 1'b1;
        if (stall_slot == 4'hf) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pattern <= 16'hffff;
                2:       stall_pattern <= 16'haaaa;
                3:       stall_pattern <= 16'h00ff;
                default: stall_pattern <= 16'($urandom);
            endcase
        end
    end

    task automatic send_word(input logic [7:0] data, input logic present, input logic closing);
        int gap;
        i_valid        <= 1'b1;
        i_message_byte <= data;
        i_byte_present <= present;
        i_message_end  <= closing;
        do @(posedge i_clk); while (!o_ready);
        if (present || closing) words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_digests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    task automatic send_message(input int len, input bit joined_end);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(pick_byte(), 1'b1, joined_end && (k == len - 1));
        end
        if (!joined_end || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
        if (len > longest_msg) longest_msg = len;
    endtask

    initial begin
        int start_count;
        int len;
        bit drained;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        drain_digests();

        start_count = words_sent;
        drained     = 1'b0;
        while (words_sent - start_count < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(11, 40);
                2: begin
                    case ($urandom_range(0, 5))
                        0:       len = 55;
                        1:       len = 56;
                        2:       len = 63;
                        3:       len = 64;
                        4:       len = 119;
                        default: len = 120;
                    endcase
                end
                default: len = $urandom_range(1, 10);
            endcase
            send_message(len, $urandom_range(0, 1));
            if (!drained && words_sent - start_count >= RANDOM_WORDS / 2) begin
                drain_digests();
                drained = 1'b1;
            end
        end

        drain_digests();
        repeat (300) @(posedge i_clk);

        $display("Hashed %0d messages from %0d input words, the longest %0d bytes.",
                 sb.messages_closed, words_sent, longest_msg);
        $display("Compared %0d digest words; %0d mismatches.", sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
